// ===== design/assert_macros.svh =====
// Assertion macros shared by the thinning engine modules.
// No dependencies; taken in by `include inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Antecedent at an edge implies consequent at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/itt_pkg.sv =====
// Package for the thinning engine: request codes, register map, memory
// control struct and the per-pixel deletion test. No dependencies.
package itt_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam int PADDR_W = 4;
    localparam logic [PADDR_W-1:0] ADDR_WIDTH  = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_HEIGHT = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_ITER   = 4'h8;

    localparam logic [8:0] RST_WIDTH  = 9'd256;
    localparam logic [8:0] RST_HEIGHT = 9'd256;
    localparam logic [7:0] RST_ITER   = 8'd5;

    typedef struct packed {
        logic fr_we;
        logic sn_we;
        logic sn_wdata;
    } mem_ctl_t;

    // nb[0] is the centre, nb[8:1] the ring N, NE, E, SE, S, SW, W, NW.
    function automatic logic zs_delete(input logic [8:0] nb, input logic second);
        logic [3:0] sum;
        logic [3:0] trans;
        logic [7:0] p;
        logic       rule;
        p     = nb[8:1];
        sum   = 4'd0;
        trans = 4'd0;
        for (int k = 0; k < 8; k++)
        begin
            sum = sum + 4'(p[k]);
            if (!p[k] && p[(k + 1) % 8])
                trans = trans + 4'd1;
        end
        if (!second)
            rule = !(p[0] & p[2] & p[4]) && !(p[2] & p[4] & p[6]);
        else
            rule = !(p[0] & p[2] & p[6]) && !(p[0] & p[4] & p[6]);
        return nb[0] && (sum >= 4'd2) && (sum <= 4'd6) && (trans == 4'd1) && rule;
    endfunction

endpackage

// ===== design/itt_store.sv =====
// Frame store (8-bit grey) and nonzero snapshot (1 bit), both single-port
// synchronous RAMs with registered read. Depends on itt_pkg.
module itt_store #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic             clk,
    input  logic [AW-1:0]    fr_addr,
    input  logic [7:0]       fr_wdata,
    input  logic [AW-1:0]    sn_addr,
    input  itt_pkg::mem_ctl_t ctl,
    output logic [7:0]       fr_rdata,
    output logic             sn_rdata
);
    import itt_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [7:0] frame_mem [DEPTH];
    logic       snap_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.fr_we)
            frame_mem[fr_addr] <= fr_wdata;
        fr_rdata <= frame_mem[fr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sn_we)
            snap_mem[sn_addr] <= ctl.sn_wdata;
        sn_rdata <= snap_mem[sn_addr];
    end

endmodule

// ===== design/itt_seq.sv =====
// Request sequencer: pixel write/read and the thinning walk over the store.
// Depends on itt_pkg, itt_store and assert_macros.svh.
module itt_seq #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] req_type,
    input  logic [7:0] row,
    input  logic [7:0] col,
    input  logic [7:0] pixel_value,
    input  logic [8:0] frame_width,
    input  logic [8:0] frame_height,
    input  logic [7:0] max_iterations,
    output logic       busy,
    output logic       done,
    output logic [7:0] read_value,
    output logic [7:0] passes_done,
    output logic       converged
);
    import itt_pkg::*;
    `include "assert_macros.svh"

    localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int DWW = $clog2(MAX_WIDTH + 2);
    localparam int DWH = $clog2(MAX_HEIGHT + 2);
    localparam int DWM = (DWW > DWH) ? DWW : DWH;
    localparam int DW  = (DWM > 9) ? DWM : 9;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_RDWAIT = 4'd2;
    localparam logic [3:0] S_CP_RD  = 4'd3;
    localparam logic [3:0] S_CP_WR  = 4'd4;
    localparam logic [3:0] S_NB     = 4'd5;
    localparam logic [3:0] S_EVAL   = 4'd6;
    localparam logic [3:0] S_SP_END = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    req_reg, req_next;
    logic          inside_reg, inside_next;
    logic [7:0]    val_reg, val_next;
    logic [RW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic [3:0]    k_reg, k_next;
    logic [8:0]    nb_reg, nb_next;
    logic          sub_reg, sub_next;
    logic          del_reg, del_next;
    logic [7:0]    iter_reg, iter_next;
    logic [7:0]    pass_reg, pass_next;
    logic          conv_reg, conv_next;
    logic [7:0]    rd_reg, rd_next;

    logic [DW-1:0] uw, uh;
    logic          frame_empty, frame_small;
    logic          last_c, last_r, last_ic, last_ir;
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;
    logic [AW-1:0] cur_addr, nb_addr;
    logic [7:0]    fr_rdata;
    logic [7:0]    fr_wdata;
    logic          sn_rdata;
    logic          kill;
    mem_ctl_t      ctl;

    assign uw = (DW'(frame_width) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(frame_width);
    assign uh = (DW'(frame_height) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(frame_height);
    assign frame_empty = (uw == '0) || (uh == '0);
    assign frame_small = (uw < DW'(3)) || (uh < DW'(3));
    assign last_c  = (DW'(c_reg) + DW'(1)) == uw;
    assign last_r  = (DW'(r_reg) + DW'(1)) == uh;
    assign last_ic = (DW'(c_reg) + DW'(2)) == uw;
    assign last_ir = (DW'(r_reg) + DW'(2)) == uh;

    // ring order after the centre: N, NE, E, SE, S, SW, W, NW
    always_comb
    begin
        nr = r_reg;
        nc = c_reg;
        case (k_reg)
            4'd1:
            begin
                nr = r_reg - RW'(1);
            end
            4'd2:
            begin
                nr = r_reg - RW'(1);
                nc = c_reg + CW'(1);
            end
            4'd3:
            begin
                nc = c_reg + CW'(1);
            end
            4'd4:
            begin
                nr = r_reg + RW'(1);
                nc = c_reg + CW'(1);
            end
            4'd5:
            begin
                nr = r_reg + RW'(1);
            end
            4'd6:
            begin
                nr = r_reg + RW'(1);
                nc = c_reg - CW'(1);
            end
            4'd7:
            begin
                nc = c_reg - CW'(1);
            end
            4'd8:
            begin
                nr = r_reg - RW'(1);
                nc = c_reg - CW'(1);
            end
            default:
            begin
                nr = r_reg;
                nc = c_reg;
            end
        endcase
    end

    assign cur_addr = AW'(r_reg) * AW'(MAX_WIDTH) + AW'(c_reg);
    assign nb_addr  = AW'(nr) * AW'(MAX_WIDTH) + AW'(nc);
    assign kill     = zs_delete(nb_reg, sub_reg);

    always_comb
    begin
        ctl.fr_we    = ((state_reg == S_EXEC) && (req_reg == REQ_WRITE) && inside_reg) ||
                       ((state_reg == S_EVAL) && kill);
        ctl.sn_we    = (state_reg == S_CP_WR);
        ctl.sn_wdata = (fr_rdata != 8'd0);
        fr_wdata     = (state_reg == S_EXEC) ? val_reg : 8'd0;
    end

    itt_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .AW        (AW)
    ) u_store (
        .clk     (clk),
        .fr_addr (cur_addr),
        .fr_wdata(fr_wdata),
        .sn_addr ((state_reg == S_NB) ? nb_addr : cur_addr),
        .ctl     (ctl),
        .fr_rdata(fr_rdata),
        .sn_rdata(sn_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        inside_next = inside_reg;
        val_next    = val_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        k_next      = k_reg;
        nb_next     = nb_reg;
        sub_next    = sub_reg;
        del_next    = del_reg;
        iter_next   = iter_reg;
        pass_next   = pass_reg;
        conv_next   = conv_reg;
        rd_next     = rd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = req_type;
                    inside_next = (DW'(row) < uh) && (DW'(col) < uw);
                    val_next    = pixel_value;
                    r_next      = RW'(row);
                    c_next      = CW'(col);
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rd_next = 8'd0;
                case (req_reg)
                    REQ_READ:
                    begin
                        state_next = S_RDWAIT;
                    end
                    REQ_RUN:
                    begin
                        pass_next = 8'd0;
                        conv_next = 1'b0;
                        iter_next = 8'd0;
                        sub_next  = 1'b0;
                        del_next  = 1'b0;
                        r_next    = '0;
                        c_next    = '0;
                        if (max_iterations == 8'd0)
                            state_next = S_DONE;
                        else if (frame_empty)
                            state_next = S_SP_END;
                        else
                            state_next = S_CP_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RDWAIT:
            begin
                rd_next    = inside_reg ? fr_rdata : 8'd0;
                state_next = S_DONE;
            end
            S_CP_RD:
            begin
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                state_next = S_CP_RD;
                if (last_c)
                begin
                    c_next = '0;
                    if (last_r)
                    begin
                        if (frame_small)
                            state_next = S_SP_END;
                        else
                        begin
                            r_next     = RW'(1);
                            c_next     = CW'(1);
                            k_next     = 4'd0;
                            state_next = S_NB;
                        end
                    end
                    else
                        r_next = r_reg + RW'(1);
                end
                else
                    c_next = c_reg + CW'(1);
            end
            S_NB:
            begin
                // read data arrives in the cycle after its address is presented
                if (k_reg != 4'd0)
                    nb_next[k_reg - 4'd1] = sn_rdata;
                if (k_reg == 4'd9)
                    state_next = S_EVAL;
                else
                    k_next = k_reg + 4'd1;
            end
            S_EVAL:
            begin
                if (kill)
                    del_next = 1'b1;
                k_next     = 4'd0;
                state_next = S_NB;
                if (last_ic)
                begin
                    c_next = CW'(1);
                    if (last_ir)
                        state_next = S_SP_END;
                    else
                        r_next = r_reg + RW'(1);
                end
                else
                    c_next = c_reg + CW'(1);
            end
            S_SP_END:
            begin
                r_next = '0;
                c_next = '0;
                state_next = frame_empty ? S_SP_END : S_CP_RD;
                if (!sub_reg)
                    sub_next = 1'b1;
                else
                begin
                    pass_next = iter_reg + 8'd1;
                    if (!del_reg)
                    begin
                        conv_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else if ((iter_reg + 8'd1) == max_iterations)
                        state_next = S_DONE;
                    else
                    begin
                        iter_next = iter_reg + 8'd1;
                        sub_next  = 1'b0;
                        del_next  = 1'b0;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 8'd0;
            conv_reg  <= 1'b0;
            k_reg     <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            conv_reg  <= conv_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        inside_reg <= inside_next;
        val_reg    <= val_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        nb_reg     <= nb_next;
        sub_reg    <= sub_next;
        del_reg    <= del_next;
        iter_reg   <= iter_next;
        rd_reg     <= rd_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_DONE);
    assign read_value  = rd_reg;
    assign passes_done = pass_reg;
    assign converged   = conv_reg;

    `ASSERT_ALWAYS(a_k_range, clk, rst_n, k_reg <= 4'd9)
    `ASSERT_IMPLIES(a_no_snap_wr_nb, clk, rst_n, state_reg == S_NB, !ctl.sn_we)
    `ASSERT_IMPLIES(a_conv_pass, clk, rst_n, done && conv_reg, pass_reg != 8'd0)

endmodule

// ===== design/iterative_thinning_engine.sv =====
// Top level of the thinning engine: APB registers, input handshake and
// result register. Depends on itt_pkg, itt_seq and assert_macros.svh.
//
// One request is handled at a time; one result per request. A pixel write
// passes through the execute and done states to its result; a read also
// waits in a read-wait state for the registered read of the single frame
// store port. Each sub-pass of a run first copies the nonzero map into
// the snapshot RAM (one frame read and one snapshot write per pixel),
// then reads each interior pixel's nine snapshot bits through the one
// snapshot port and decides; two sub-passes per iteration, at most
// max_iterations of them. A new request is held off while a finished
// result waits; it can be taken at the same edge as the result transfer.
module iterative_thinning_engine #(
    parameter int MAX_WIDTH  = itt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = itt_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [itt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  req_type,
    input  logic [7:0]                  row,
    input  logic [7:0]                  col,
    input  logic [7:0]                  pixel_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  read_value,
    output logic [7:0]                  passes_done,
    output logic                        converged
);
    import itt_pkg::*;
    `include "assert_macros.svh"

    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic [7:0] iter_reg;
    logic       out_valid_reg;
    logic [7:0] rd_reg;
    logic [7:0] pass_reg;
    logic       conv_reg;
    logic       busy, done, accept, cfg_wr;
    logic [7:0] s_rd, s_pass;
    logic       s_conv;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            iter_reg   <= RST_ITER;
        end
        else if (cfg_wr)
        begin
            case (paddr)
                ADDR_WIDTH:  width_reg  <= pwdata[8:0];
                ADDR_HEIGHT: height_reg <= pwdata[8:0];
                ADDR_ITER:   iter_reg   <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_WIDTH:  prdata = {23'd0, width_reg};
            ADDR_HEIGHT: prdata = {23'd0, height_reg};
            ADDR_ITER:   prdata = {24'd0, iter_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign in_stall = busy || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    itt_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept),
        .req_type      (req_type),
        .row           (row),
        .col           (col),
        .pixel_value   (pixel_value),
        .frame_width   (width_reg),
        .frame_height  (height_reg),
        .max_iterations(iter_reg),
        .busy          (busy),
        .done          (done),
        .read_value    (s_rd),
        .passes_done   (s_pass),
        .converged     (s_conv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rd_reg   <= s_rd;
            pass_reg <= s_pass;
            conv_reg <= s_conv;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = rd_reg;
    assign passes_done = pass_reg;
    assign converged   = conv_reg;

    // the result register has always drained before the next result lands
    `ASSERT_IMPLIES(a_out_free, clk, rst_n, done, !out_valid_reg)
    `ASSERT_IMPLIES(a_stall_busy, clk, rst_n, busy, in_stall)
    `ASSERT_IMPLIES(a_new_result, clk, rst_n, $rose(out_valid_reg), $past(done))

endmodule
